// ===== hdl/tcc_pkg.sv =====
// tcc_pkg: shared constants, widths and the cordic arctangent table
// for the tilt-compensated compass angle pipeline. No dependencies.

package tcc_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // square root datapath: radicand is the sum of squares scaled to 62 bits
    localparam int ROOT_W = 31;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // cordic datapath
    localparam int ATAN_LEN = 24;
    localparam int ANG_W    = 32;
    localparam int CXW      = 44;
    localparam int OUT_W    = 16;

    localparam logic [ANG_W-1:0] ANG_HALF  = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_ROUND = 32'h0000_8000;

    typedef logic signed [OUT_W-1:0] angle_t;

    // atan(2^-i) in binary angle, 2^32 per turn
    function automatic logic [ANG_W-1:0] tcc_atan(input int idx);
        logic [ANG_W-1:0] a;
        case (idx)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2F9;
            15:      a = 32'h0000517C;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A2F;
            19:      a = 32'h00000517;
            20:      a = 32'h0000028B;
            21:      a = 32'h00000145;
            22:      a = 32'h000000A2;
            23:      a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/tilt_compensated_compass_angles_unit.sv =====
// tilt_compensated_compass_angles_unit: heading, inclination and roll of the
// device x axis from one magnetometer and one accelerometer sample.
// Depends on tcc_pkg, tcc_delay, tcc_isqrt and tcc_cordic.
//
//   channel | ports                                  | direction
//   request | s_valid/s_ready, s_mag_*, s_accel_*    | in
//   result  | m_valid/m_ready, m_heading, m_inclination, m_roll, m_degenerate | out
//
// one request per cycle while the output register is empty or taken; latency is set
// by the 31-cell square root chain and the cordic cell chain
// (NPS = max(1, SAMPLE_BITS-8) prescale cells, NST = min(CORDIC_STAGES, 24))
// the whole pipeline advances whenever the output register is empty or taken
// reset clears the valid bits only

module tilt_compensated_compass_angles_unit #(
    parameter int SAMPLE_BITS   = tcc_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = tcc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_mag_x,
    input  logic signed [SAMPLE_BITS-1:0] s_mag_y,
    input  logic signed [SAMPLE_BITS-1:0] s_mag_z,
    input  logic signed [SAMPLE_BITS-1:0] s_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] s_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] s_accel_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tcc_pkg::angle_t               m_heading,
    output tcc_pkg::angle_t               m_inclination,
    output tcc_pkg::angle_t               m_roll,
    output logic                          m_degenerate
);
    import tcc_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int F     = ROOT_W - S;
    localparam int P_W   = 2 * S;
    localparam int E_W   = 2 * S + 1;
    localparam int NW    = (E_W > 32) ? E_W : 32;
    localparam int NSH   = (2 * S - 30 > 1) ? 2 * S - 30 : 1;
    localparam int IN_W  = 32 + S;
    localparam int NST   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int NPS   = (IN_W - 40 > 1) ? IN_W - 40 : 1;
    localparam int CL    = NPS + NST + 2;
    localparam int VLEN  = 34 + CL;
    localparam int DLY_E = 29 - NSH;
    localparam int DLY_G = 31;
    localparam int DLY_D = 32 + CL;
    localparam int NXP_W = 31 + S;

    localparam logic signed [NW-1:0] ELIM_P = {{(NW-31){1'b0}}, 1'b1, {30{1'b0}}};
    localparam logic signed [NW-1:0] ELIM_N = -ELIM_P;

    logic en;

    // stage A: cross product terms and squares
    logic signed [P_W-1:0] a_p_reg [6];
    logic [P_W-1:0]        a_sq_reg [3];
    logic signed [S-1:0]   a_g_reg [3];

    // stage B: east vector, square sums
    logic signed [E_W-1:0] b_ex_w, b_ey_w, b_ez_w;
    logic signed [NW-1:0]  b_e_reg [3];
    logic                  b_deg_reg;
    logic [P_W-1:0]        b_sum_reg;
    logic [P_W-1:0]        b_syz_reg;
    logic signed [S-1:0]   b_g_reg [3];

    // normalize cells
    logic signed [NW-1:0]  n_e_reg [NSH][3];
    logic signed [S-1:0]   n_gy_reg [NSH];
    logic signed [S-1:0]   n_gz_reg [NSH];

    logic signed [NXP_W-1:0] c_pa_reg, c_pb_reg;
    logic [30:0]             c_ex_reg;
    logic signed [IN_W-1:0]  d_nx_reg;
    logic [30:0]             d_ex_reg;

    logic [30+IN_W:0]      ex_nx_dly;
    logic [3*S-1:0]        g_dly;
    logic [ROOT_W-1:0]     rg, ryz;
    logic                  deg_dly;

    // stage F: heading numerator and operands for the angle units
    logic signed [62:0]     f_hp_reg;
    logic signed [IN_W-1:0] f_nx_reg;
    logic [ROOT_W-1:0]      f_ryz_reg;
    logic signed [S-1:0]    f_gx_reg, f_gy_reg, f_gz_reg;

    logic signed [IN_W-1:0] hy, gx_e, gz_e, iy, ix, ry, rx;
    angle_t                 head_a, incl_a, roll_a;

    logic [VLEN-1:0] v_reg;
    logic            m_valid_reg;
    angle_t          m_heading_reg, m_inclination_reg, m_roll_reg;
    logic            m_degenerate_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_p_reg[0]  <= s_accel_y * s_mag_z;
            a_p_reg[1]  <= s_accel_z * s_mag_y;
            a_p_reg[2]  <= s_accel_z * s_mag_x;
            a_p_reg[3]  <= s_accel_x * s_mag_z;
            a_p_reg[4]  <= s_accel_x * s_mag_y;
            a_p_reg[5]  <= s_accel_y * s_mag_x;
            a_sq_reg[0] <= P_W'(s_accel_x * s_accel_x);
            a_sq_reg[1] <= P_W'(s_accel_y * s_accel_y);
            a_sq_reg[2] <= P_W'(s_accel_z * s_accel_z);
            a_g_reg[0]  <= s_accel_x;
            a_g_reg[1]  <= s_accel_y;
            a_g_reg[2]  <= s_accel_z;
        end
    end

    assign b_ex_w = E_W'(a_p_reg[0]) - E_W'(a_p_reg[1]);
    assign b_ey_w = E_W'(a_p_reg[2]) - E_W'(a_p_reg[3]);
    assign b_ez_w = E_W'(a_p_reg[4]) - E_W'(a_p_reg[5]);

    always_ff @(posedge aclk) begin
        if (en) begin
            b_e_reg[0] <= NW'(b_ex_w);
            b_e_reg[1] <= NW'(b_ey_w);
            b_e_reg[2] <= NW'(b_ez_w);
            b_deg_reg  <= (b_ex_w == '0) && (b_ey_w == '0) && (b_ez_w == '0);
            b_sum_reg  <= a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
            b_syz_reg  <= a_sq_reg[1] + a_sq_reg[2];
            b_g_reg    <= a_g_reg;
        end
    end

    // shift all east components together until each is below 2^30
    genvar j;
    generate
        for (j = 0; j < NSH; j++) begin : g_norm
            logic signed [NW-1:0] e_i [3];
            logic signed [S-1:0]  gy_i, gz_i;
            logic                 big;

            if (j == 0) begin : g_src
                assign e_i  = b_e_reg;
                assign gy_i = b_g_reg[1];
                assign gz_i = b_g_reg[2];
            end else begin : g_chain
                assign e_i  = n_e_reg[j-1];
                assign gy_i = n_gy_reg[j-1];
                assign gz_i = n_gz_reg[j-1];
            end

            assign big = (e_i[0] >= ELIM_P) || (e_i[0] <= ELIM_N) ||
                         (e_i[1] >= ELIM_P) || (e_i[1] <= ELIM_N) ||
                         (e_i[2] >= ELIM_P) || (e_i[2] <= ELIM_N);

            always_ff @(posedge aclk) begin
                if (en) begin
                    n_e_reg[j][0] <= big ? (e_i[0] >>> 1) : e_i[0];
                    n_e_reg[j][1] <= big ? (e_i[1] >>> 1) : e_i[1];
                    n_e_reg[j][2] <= big ? (e_i[2] >>> 1) : e_i[2];
                    n_gy_reg[j]   <= gy_i;
                    n_gz_reg[j]   <= gz_i;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            c_pa_reg <= $signed(n_e_reg[NSH-1][1][30:0]) * n_gz_reg[NSH-1];
            c_pb_reg <= $signed(n_e_reg[NSH-1][2][30:0]) * n_gy_reg[NSH-1];
            c_ex_reg <= n_e_reg[NSH-1][0][30:0];
            d_nx_reg <= IN_W'(c_pa_reg) - IN_W'(c_pb_reg);
            d_ex_reg <= c_ex_reg;
        end
    end

    tcc_delay #(.W(31 + IN_W), .DEPTH(DLY_E)) u_dly_e (
        .aclk (aclk),
        .en   (en),
        .d    ({d_ex_reg, d_nx_reg}),
        .q    (ex_nx_dly)
    );

    tcc_delay #(.W(3 * S), .DEPTH(DLY_G)) u_dly_g (
        .aclk (aclk),
        .en   (en),
        .d    ({b_g_reg[0], b_g_reg[1], b_g_reg[2]}),
        .q    (g_dly)
    );

    tcc_delay #(.W(1), .DEPTH(DLY_D)) u_dly_d (
        .aclk (aclk),
        .en   (en),
        .d    (b_deg_reg),
        .q    (deg_dly)
    );

    tcc_isqrt u_sqrt_g (
        .aclk     (aclk),
        .en       (en),
        .rad_in   ({b_sum_reg, {(2*F){1'b0}}}),
        .root_out (rg)
    );

    tcc_isqrt u_sqrt_yz (
        .aclk     (aclk),
        .en       (en),
        .rad_in   ({b_syz_reg, {(2*F){1'b0}}}),
        .root_out (ryz)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            f_hp_reg  <= $signed(ex_nx_dly[30+IN_W -: 31]) * $signed({1'b0, rg});
            f_nx_reg  <= $signed(ex_nx_dly[IN_W-1:0]);
            f_ryz_reg <= ryz;
            f_gx_reg  <= $signed(g_dly[3*S-1 -: S]);
            f_gy_reg  <= $signed(g_dly[2*S-1 -: S]);
            f_gz_reg  <= $signed(g_dly[S-1:0]);
        end
    end

    // heading y = E'x * |g|, back to integer scale
    assign hy   = $signed(f_hp_reg[62:F]);
    assign gx_e = IN_W'(f_gx_reg);
    assign gz_e = IN_W'(f_gz_reg);
    assign iy   = (-gx_e) <<< F;
    assign ix   = $signed(IN_W'(f_ryz_reg));
    assign ry   = IN_W'(f_gy_reg);
    assign rx   = -gz_e;

    tcc_cordic #(.IN_W(IN_W), .NST(NST), .NPS(NPS)) u_cordic_head (
        .aclk  (aclk),
        .en    (en),
        .x_in  (f_nx_reg),
        .y_in  (hy),
        .angle (head_a)
    );

    tcc_cordic #(.IN_W(IN_W), .NST(NST), .NPS(NPS)) u_cordic_incl (
        .aclk  (aclk),
        .en    (en),
        .x_in  (ix),
        .y_in  (iy),
        .angle (incl_a)
    );

    tcc_cordic #(.IN_W(IN_W), .NST(NST), .NPS(NPS)) u_cordic_roll (
        .aclk  (aclk),
        .en    (en),
        .x_in  (rx),
        .y_in  (ry),
        .angle (roll_a)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= {v_reg[VLEN-2:0], s_valid};
            m_valid_reg <= v_reg[VLEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_heading_reg     <= deg_dly ? '0 : head_a;
            m_inclination_reg <= deg_dly ? '0 : incl_a;
            m_roll_reg        <= deg_dly ? '0 : roll_a;
            m_degenerate_reg  <= deg_dly;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_heading     = m_heading_reg;
    assign m_inclination = m_inclination_reg;
    assign m_roll        = m_roll_reg;
    assign m_degenerate  = m_degenerate_reg;

endmodule

// ===== hdl/tcc_delay.sv =====
// tcc_delay: a row of register cells that shifts a word along by one cell
// per enabled cycle. Uses no package.

module tcc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dl_reg [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (en) begin
                        dl_reg[k] <= d;
                    end
                end
            end else begin : g_next
                always_ff @(posedge aclk) begin
                    if (en) begin
                        dl_reg[k] <= dl_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign q = dl_reg[DEPTH-1];

endmodule

// ===== hdl/tcc_isqrt.sv =====
// tcc_isqrt: floor square root of a 62-bit radicand, one root bit per cell,
// each cell registered and advancing while en is high. Depends on tcc_pkg.

module tcc_isqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [tcc_pkg::RAD_W-1:0]  rad_in,
    output logic [tcc_pkg::ROOT_W-1:0] root_out
);
    import tcc_pkg::*;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_cell
            logic [REM_W-1:0]  rem_i;
            logic [ROOT_W-1:0] root_i;
            logic [RAD_W-1:0]  rad_i;
            logic [REM_W+1:0]  rem_t;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  diff;
            logic              ge;

            if (k == 0) begin : g_src
                assign rem_i  = '0;
                assign root_i = '0;
                assign rad_i  = rad_in;
            end else begin : g_chain
                assign rem_i  = rem_reg[k-1];
                assign root_i = root_reg[k-1];
                assign rad_i  = rad_reg[k-1];
            end

            always_comb begin
                rem_t = {rem_i, rad_i[RAD_W-1 -: 2]};
                trial = {2'b00, root_i, 2'b01};
                ge    = (rem_t >= trial);
                diff  = rem_t - trial;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
                    root_reg[k] <= {root_i[ROOT_W-2:0], ge};
                    rad_reg[k]  <= {rad_i[RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root_out = root_reg[ROOT_W-1];

endmodule

// ===== hdl/tcc_cordic.sv =====
// tcc_cordic: pipelined atan2 as a chain of cells: input cell, prescale
// cells, half-plane fold cell, then vectoring cells. Depends on tcc_pkg.

module tcc_cordic #(
    parameter int IN_W = 48,
    parameter int NST  = 16,
    parameter int NPS  = 8
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] x_in,
    input  logic signed [IN_W-1:0] y_in,
    output tcc_pkg::angle_t        angle
);
    import tcc_pkg::*;

    localparam int CW = (IN_W + 1 > 42) ? IN_W + 1 : 42;
    localparam logic signed [CW-1:0] LIM_P = {{(CW-41){1'b0}}, 1'b1, {40{1'b0}}};
    localparam logic signed [CW-1:0] LIM_N = -LIM_P;

    logic signed [CW-1:0]  p_x_reg [NPS+1];
    logic signed [CW-1:0]  p_y_reg [NPS+1];
    logic                  p_z_reg [NPS+1];
    logic signed [CXW-1:0] r_x_reg [NST+1];
    logic signed [CXW-1:0] r_y_reg [NST+1];
    logic [ANG_W-1:0]      r_a_reg [NST+1];
    logic                  r_z_reg [NST+1];
    logic [ANG_W-1:0]      rnd;

    genvar j, i;
    generate
        for (j = 0; j <= NPS; j++) begin : g_pre
            if (j == 0) begin : g_in
                always_ff @(posedge aclk) begin
                    if (en) begin
                        p_x_reg[j] <= CW'(x_in);
                        p_y_reg[j] <= CW'(y_in);
                        p_z_reg[j] <= (x_in == '0) && (y_in == '0);
                    end
                end
            end else begin : g_scale
                logic big;
                assign big = (p_x_reg[j-1] >= LIM_P) || (p_x_reg[j-1] <= LIM_N) ||
                             (p_y_reg[j-1] >= LIM_P) || (p_y_reg[j-1] <= LIM_N);
                always_ff @(posedge aclk) begin
                    if (en) begin
                        p_x_reg[j] <= big ? (p_x_reg[j-1] >>> 1) : p_x_reg[j-1];
                        p_y_reg[j] <= big ? (p_y_reg[j-1] >>> 1) : p_y_reg[j-1];
                        p_z_reg[j] <= p_z_reg[j-1];
                    end
                end
            end
        end

        for (i = 0; i <= NST; i++) begin : g_rot
            if (i == 0) begin : g_fold
                logic signed [CXW-1:0] fx, fy;
                assign fx = CXW'(p_x_reg[NPS]);
                assign fy = CXW'(p_y_reg[NPS]);
                // left half plane: rotate by a half turn first
                always_ff @(posedge aclk) begin
                    if (en) begin
                        r_x_reg[i] <= fx[CXW-1] ? -fx : fx;
                        r_y_reg[i] <= fx[CXW-1] ? -fy : fy;
                        r_a_reg[i] <= fx[CXW-1] ? ANG_HALF : '0;
                        r_z_reg[i] <= p_z_reg[NPS];
                    end
                end
            end else begin : g_step
                logic signed [CXW-1:0] dx, dy;
                assign dx = r_y_reg[i-1] >>> (i - 1);
                assign dy = r_x_reg[i-1] >>> (i - 1);
                always_ff @(posedge aclk) begin
                    if (en) begin
                        if (!r_y_reg[i-1][CXW-1]) begin
                            r_x_reg[i] <= r_x_reg[i-1] + dx;
                            r_y_reg[i] <= r_y_reg[i-1] - dy;
                            r_a_reg[i] <= r_a_reg[i-1] + tcc_atan(i - 1);
                        end else begin
                            r_x_reg[i] <= r_x_reg[i-1] - dx;
                            r_y_reg[i] <= r_y_reg[i-1] + dy;
                            r_a_reg[i] <= r_a_reg[i-1] - tcc_atan(i - 1);
                        end
                        r_z_reg[i] <= r_z_reg[i-1];
                    end
                end
            end
        end
    endgenerate

    assign rnd   = r_a_reg[NST] + ANG_ROUND;
    assign angle = r_z_reg[NST] ? '0 : angle_t'(rnd[ANG_W-1 -: OUT_W]);

endmodule

// ===== hdl/tcc_checker.sv =====
// tcc_checker: port-level checks for tilt_compensated_compass_angles_unit,
// bound to the top level below. Depends on tcc_pkg.

module tcc_checker #(
    parameter int SAMPLE_BITS = tcc_pkg::SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [SAMPLE_BITS-1:0] s_mag_x,
    input logic signed [SAMPLE_BITS-1:0] s_mag_y,
    input logic signed [SAMPLE_BITS-1:0] s_mag_z,
    input logic signed [SAMPLE_BITS-1:0] s_accel_x,
    input logic signed [SAMPLE_BITS-1:0] s_accel_y,
    input logic signed [SAMPLE_BITS-1:0] s_accel_z,
    input logic                          m_valid,
    input logic                          m_ready,
    input tcc_pkg::angle_t               m_heading,
    input tcc_pkg::angle_t               m_inclination,
    input tcc_pkg::angle_t               m_roll,
    input logic                          m_degenerate
);
    import tcc_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading) &&
        $stable(m_inclination) && $stable(m_roll) && $stable(m_degenerate))
        else $error("result changed while stalled");

    // degenerate results carry zero angles
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_heading == '0 && m_inclination == '0 &&
        m_roll == '0)
        else $error("degenerate result with nonzero angle");

    // the pipeline takes requests whenever the output side is not stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("request refused while output free");

    // no result straight out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind tilt_compensated_compass_angles_unit tcc_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_tcc_checker (.*);
